// ===== rtl/sbpt_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sounder beep pattern timer package
// Shared types, command codes and timing constants.
// ----------------------------------------------------------------------------
package sbpt_pkg;

	// Command codes carried in the slave-side tuser
	localparam logic [2:0] CMD_TICK  = 3'd0;
	localparam logic [2:0] CMD_SETUP = 3'd1;
	localparam logic [2:0] CMD_TEST  = 3'd2;
	localparam logic [2:0] CMD_FREQ  = 3'd3;
	localparam logic [2:0] CMD_HALT  = 3'd4;

	localparam logic [15:0] TEST_ON_US    = 16'd750;
	localparam logic [15:0] TEST_OFF_US   = 16'd1500;
	localparam logic [16:0] TEST_FIRST_US = 17'd2500;

	// x / 3 == (x * RECIP3) >> RECIP3_SHIFT, exact for every 16-bit x
	localparam int          RECIP3_SHIFT = 17;
	localparam logic [31:0] RECIP3       = 32'd43691;

	localparam logic [2:0] PHASE_SEVEN = 3'd6;
	localparam logic [2:0] PHASE_EIGHT = 3'd7;

	typedef struct packed {
		logic [2:0]  command;
		logic [15:0] period_us;
	} item_t;

	typedef struct packed {
		logic pin_level;
		logic status;
		logic running;
	} result_t;

endpackage

// ===== rtl/sbpt_in_stage.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sounder beep pattern timer input stage
// Registers one incoming item and holds it until the core consumes it.
// ----------------------------------------------------------------------------
module sbpt_in_stage
	import sbpt_pkg::*;
(
	input  logic  clk,
	input  logic  arst_n,
	input  logic  in_valid,
	output logic  in_ready,
	input  item_t in_item,
	input  logic  take,
	output logic  item_valid_s1,
	output item_t item_s1
);

	assign in_ready = !item_valid_s1 || take;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			item_valid_s1 <= 1'b0;
		end else if (in_ready) begin
			item_valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			item_s1 <= in_item;
		end
	end

endmodule

// ===== rtl/sbpt_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sounder beep pattern timer core
// Holds the pattern state and applies one item per enabled cycle.
// ----------------------------------------------------------------------------
module sbpt_core
	import sbpt_pkg::*;
(
	input  logic    clk,
	input  logic    arst_n,
	input  logic    step,
	input  item_t   item,
	output result_t result
);

	logic        pin_q;
	logic        active_q;
	logic [2:0]  phase_q;
	logic [16:0] remaining_q;
	logic [15:0] high_q;
	logic [15:0] low_q;

	logic        pin_d;
	logic        active_d;
	logic [2:0]  phase_d;
	logic [16:0] remaining_d;
	logic [15:0] high_d;
	logic [15:0] low_d;
	logic        status;
	logic [31:0] product;
	logic [14:0] third;
	logic [16:0] period;
	logic        expire_pin;

	assign product = 32'(item.period_us) * RECIP3;
	assign third   = product[RECIP3_SHIFT +: 15];

	// Period and pin level of the phase that follows an expiry
	always_comb begin
		if (phase_q == PHASE_EIGHT) begin
			expire_pin = 1'b0;
			period     = {low_q, 1'b0};
		end else if (phase_q == PHASE_SEVEN) begin
			expire_pin = 1'b1;
			period     = {1'b0, low_q};
		end else if (!phase_q[0]) begin
			expire_pin = 1'b1;
			period     = {1'b0, high_q};
		end else begin
			expire_pin = 1'b0;
			period     = {1'b0, low_q};
		end
	end

	always_comb begin
		pin_d       = pin_q;
		active_d    = active_q;
		phase_d     = phase_q;
		remaining_d = remaining_q;
		high_d      = high_q;
		low_d       = low_q;
		status      = 1'b0;
		case (item.command)
			CMD_TICK: begin
				if (active_q) begin
					if (remaining_q <= 17'd1) begin
						pin_d       = expire_pin;
						remaining_d = (period == 17'd0) ? 17'd1 : period;
						phase_d     = phase_q + 3'd1;
					end else begin
						remaining_d = remaining_q - 17'd1;
					end
				end
			end
			CMD_SETUP, CMD_HALT: begin
				pin_d    = 1'b0;
				active_d = 1'b0;
			end
			CMD_TEST: begin
				high_d      = TEST_ON_US;
				low_d       = TEST_OFF_US;
				pin_d       = 1'b1;
				active_d    = 1'b1;
				remaining_d = TEST_FIRST_US;
			end
			CMD_FREQ: begin
				if (item.period_us == 16'd0) begin
					status = 1'b1;
				end else begin
					high_d      = {1'b0, third};
					low_d       = {third, 1'b0};
					pin_d       = 1'b1;
					active_d    = 1'b1;
					remaining_d = {1'b0, item.period_us};
				end
			end
			default: begin
				status = 1'b1;
			end
		endcase
	end

	assign result.pin_level = pin_d;
	assign result.status    = status;
	assign result.running   = active_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pin_q       <= 1'b0;
			active_q    <= 1'b0;
			phase_q     <= 3'd0;
			remaining_q <= 17'd0;
			high_q      <= 16'd0;
			low_q       <= 16'd0;
		end else if (step) begin
			pin_q       <= pin_d;
			active_q    <= active_d;
			phase_q     <= phase_d;
			remaining_q <= remaining_d;
			high_q      <= high_d;
			low_q       <= low_d;
		end
	end

endmodule

// ===== rtl/sbpt_out_stage.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sounder beep pattern timer output stage
// Result register; holds a result until the downstream side takes it.
// ----------------------------------------------------------------------------
module sbpt_out_stage
	import sbpt_pkg::*;
(
	input  logic    clk,
	input  logic    arst_n,
	input  logic    load,
	input  result_t result,
	output logic    can_load,
	output logic    out_valid,
	input  logic    out_ready,
	output result_t result_q
);

	assign can_load = !out_valid || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (can_load) begin
			out_valid <= load;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			result_q <= result;
		end
	end

endmodule

// ===== rtl/sounder_beep_pattern_timer_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sounder beep pattern timer
// Drives a sounder pin through a repeating eight-phase beep pattern.
// ----------------------------------------------------------------------------
// Usage:
//   Slave channel (s_*): one transfer per item. tuser carries the command
//   (tick of one microsecond, setup, test, set frequency, halt); tdata
//   carries the requested period in microseconds, used by set frequency.
//   Master channel (m_*): exactly one result transfer per item, in order,
//   carrying the pin level, the status and the running flag.
//   An accepted item passes through the input register, then the result
//   register, on its way to m_*.
//   Throughput: one item per cycle unless m_tready stalls. The pattern state
//   is read and updated by a single pass of logic between the input and
//   result registers, and the divide by three is a single 16x16 multiply by a reciprocal.
//   Reset: pin clear, countdown stopped, phase one, all timings zero; both
//   registers empty.
//   Stall: while m_tready is low the result is held; one more item may sit
//   in the input register, after which s_tready drops until the result is
//   taken.
// ----------------------------------------------------------------------------
module sounder_beep_pattern_timer_unit
	import sbpt_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [15:0] s_tdata,   // [15:0] period_us
	input  logic [2:0]  s_tuser,   // [2:0] command
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [7:0]  m_tdata    // [0] pin_level, [1] status, [2] running, [7:3] zero
);

	item_t   in_item;
	item_t   item_s1;
	logic    item_valid_s1;
	logic    can_load;
	logic    step;
	result_t result;
	result_t result_q;

	assign in_item.command   = s_tuser;
	assign in_item.period_us = s_tdata;

	// Advance the held item into the core whenever the result register has room
	assign step = item_valid_s1 && can_load;

	sbpt_in_stage u_in_stage (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (s_tvalid),
		.in_ready      (s_tready),
		.in_item       (in_item),
		.take          (step),
		.item_valid_s1 (item_valid_s1),
		.item_s1       (item_s1)
	);

	sbpt_core u_core (
		.clk    (clk),
		.arst_n (arst_n),
		.step   (step),
		.item   (item_s1),
		.result (result)
	);

	sbpt_out_stage u_out_stage (
		.clk       (clk),
		.arst_n    (arst_n),
		.load      (step),
		.result    (result),
		.can_load  (can_load),
		.out_valid (m_tvalid),
		.out_ready (m_tready),
		.result_q  (result_q)
	);

	// Pack the result, lowest field first, pad to a whole byte
	assign m_tdata = {5'd0, result_q.running, result_q.status, result_q.pin_level};

endmodule

// ===== bench/sbpt_pattern_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sounder beep pattern checker
// Watches both stream channels of the beep pattern timer, forecasts the pin,
// status and running flag for every accepted item and compares each result
// transfer with the oldest forecast.
// ----------------------------------------------------------------------------
module sbpt_pattern_checker
	import sbpt_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	input  logic        s_tready,
	input  logic [15:0] s_tdata,   // [15:0] period_us
	input  logic [2:0]  s_tuser,   // [2:0] command
	input  logic        m_tvalid,
	input  logic        m_tready,
	input  logic [7:0]  m_tdata,   // [0] pin_level, [1] status, [2] running, [7:3] zero
	output int          fail_count,
	output int          forecast_depth
);

	localparam logic [15:0] DUTY_DIV = 16'd3;

	// Forecast copy of the pattern state
	logic        pin_q;
	logic        counting;
	logic [2:0]  phase_idx;
	logic [16:0] ticks_left;
	logic [15:0] on_us;
	logic [15:0] off_us;

	result_t pin_forecast[$];

	// A zero period still lasts one tick
	function automatic logic [16:0] period_or_one(input logic [16:0] p);
		return (p == 17'd0) ? 17'd1 : p;
	endfunction

	task automatic step_pattern(input logic [2:0] cmd, input logic [15:0] per,
			output result_t res);
		logic        fail;
		logic [15:0] third;
		fail = 1'b0;
		case (cmd)
			CMD_TICK: begin
				if (counting) begin
					if (ticks_left <= 17'd1) begin
						case (phase_idx)
							PHASE_EIGHT: begin
								pin_q      = 1'b0;
								ticks_left = period_or_one({off_us, 1'b0});
							end
							PHASE_SEVEN: begin
								pin_q      = 1'b1;
								ticks_left = period_or_one({1'b0, off_us});
							end
							default: begin
								pin_q      = ~phase_idx[0];
								ticks_left = period_or_one(phase_idx[0] ?
									{1'b0, off_us} : {1'b0, on_us});
							end
						endcase
						phase_idx = phase_idx + 3'd1;
					end else begin
						ticks_left = ticks_left - 17'd1;
					end
				end
			end
			CMD_SETUP, CMD_HALT: begin
				pin_q    = 1'b0;
				counting = 1'b0;
			end
			CMD_TEST: begin
				on_us      = TEST_ON_US;
				off_us     = TEST_OFF_US;
				pin_q      = 1'b1;
				counting   = 1'b1;
				ticks_left = period_or_one(TEST_FIRST_US);
			end
			CMD_FREQ: begin
				if (per == 16'd0) begin
					fail = 1'b1;
				end else begin
					third      = per / DUTY_DIV;
					on_us      = third;
					off_us     = third << 1;
					pin_q      = 1'b1;
					counting   = 1'b1;
					ticks_left = period_or_one({1'b0, per});
				end
			end
			default: begin
				fail = 1'b1;
			end
		endcase
		res.pin_level = pin_q;
		res.status    = fail;
		res.running   = counting;
	endtask

	always @(posedge clk or negedge arst_n) begin
		result_t got;
		result_t want;
		int      errs;
		if (!arst_n) begin
			pin_q      = 1'b0;
			counting   = 1'b0;
			phase_idx  = 3'd0;
			ticks_left = 17'd0;
			on_us      = 16'd0;
			off_us     = 16'd0;
			pin_forecast.delete();
			fail_count     <= 0;
			forecast_depth <= 0;
		end else begin
			errs = 0;
			// check the result before queuing a new forecast; a result is registered and never leaves with its own item
			if (m_tvalid && m_tready) begin
				got.pin_level = m_tdata[0];
				got.status    = m_tdata[1];
				got.running   = m_tdata[2];
				if (pin_forecast.size() == 0) begin
					$display("%0t: unexpected result transfer, expected none, got %b",
						$time, m_tdata);
					errs++;
				end else begin
					want = pin_forecast.pop_front();
					if (got.pin_level !== want.pin_level) begin
						$display("%0t: pin_level expected %0b got %0b",
							$time, want.pin_level, got.pin_level);
						errs++;
					end
					if (got.status !== want.status) begin
						$display("%0t: status expected %0b got %0b",
							$time, want.status, got.status);
						errs++;
					end
					if (got.running !== want.running) begin
						$display("%0t: running expected %0b got %0b",
							$time, want.running, got.running);
						errs++;
					end
					if (m_tdata[7:3] !== 5'd0) begin
						$display("%0t: tdata padding expected 00000 got %b",
							$time, m_tdata[7:3]);
						errs++;
					end
				end
			end
			if (s_tvalid && s_tready) begin
				step_pattern(s_tuser, s_tdata, want);
				pin_forecast.push_back(want);
			end
			fail_count     <= fail_count + errs;
			forecast_depth <= pin_forecast.size();
		end
	end

endmodule

// ===== bench/tb_sounder_beep_pattern_timer_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sounder beep pattern timer testbench
// Feeds ticks and requests to the timer with random gaps on the input side
// and random stalls on the result side, while a checker module forecasts
// every result and compares it. Directed items cover the stopped state, the
// failing requests, the shortest and longest frequencies and every phase of
// the pattern; random pattern runs with short periods follow, and the last
// stretch of them runs without idling.
// ----------------------------------------------------------------------------
module tb_sounder_beep_pattern_timer_unit;
	import sbpt_pkg::*;

	// cycles without any transfer before the run is abandoned
	localparam int STALL_LIMIT = 2000;
	// non-ignored items of the random part; the last ones run without idling
	localparam int ITEM_TARGET = 1850;
	localparam int QUIET_FROM  = 1650;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [15:0] s_tdata = 16'd0;   // [15:0] period_us
	logic [2:0]  s_tuser = CMD_TICK; // [2:0] command
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [7:0]  m_tdata;           // [0] pin_level, [1] status, [2] running, [7:3] zero

	int fail_count;
	int forecast_depth;

	// stimulus bookkeeping
	bit quiet = 1'b0;        // no idling on either side once set
	int gap_pct = 0;         // chance of an input gap before each item
	int sent = 0;            // items that the block does not simply ignore
	bit pattern_on = 1'b0;   // rough view of whether the countdown runs
	int stall_left = 0;

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	sounder_beep_pattern_timer_unit u_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

	sbpt_pattern_checker u_checker (
		.clk            (clk),
		.arst_n         (arst_n),
		.s_tvalid       (s_tvalid),
		.s_tready       (s_tready),
		.s_tdata        (s_tdata),
		.s_tuser        (s_tuser),
		.m_tvalid       (m_tvalid),
		.m_tready       (m_tready),
		.m_tdata        (m_tdata),
		.fail_count     (fail_count),
		.forecast_depth (forecast_depth)
	);

	// Result side: alternate runs of ready with random stall bursts;
	// hold ready high for good once the quiet stretch begins.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tready <= 1'b0;
			stall_left = 0;
		end else if (quiet) begin
			m_tready <= 1'b1;
		end else if (stall_left > 0) begin
			stall_left--;
		end else if (m_tready && $urandom_range(0, 3) == 0) begin
			m_tready <= 1'b0;
			stall_left = $urandom_range(0, 13);
		end else begin
			m_tready <= 1'b1;
			// sometimes a long run of ready so stretches without stalls occur
			stall_left = ($urandom_range(0, 4) == 0) ? $urandom_range(40, 120)
				: $urandom_range(0, 20);
		end
	end

	// Offer one item and hold it until the transfer happens. A gap, when
	// drawn, drops tvalid for a random stretch first.
	task automatic send_item(input logic [2:0] cmd, input logic [15:0] per);
		int gap;
		if (!quiet && $urandom_range(1, 100) <= gap_pct) begin
			gap = $urandom_range(1, 14);
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser  <= cmd;
		s_tdata  <= per;
		@(posedge clk);
		while (!s_tready) @(posedge clk);
		// ticks while stopped and unknown commands leave the block untouched
		if (cmd <= CMD_HALT && !(cmd == CMD_TICK && !pattern_on))
			sent++;
		if (cmd == CMD_TEST || (cmd == CMD_FREQ && per != 16'd0))
			pattern_on = 1'b1;
		else if (cmd == CMD_SETUP || cmd == CMD_HALT)
			pattern_on = 1'b0;
	endtask

	// Ticks carry random, unused period bits
	task automatic send_ticks(input int n);
		for (int i = 0; i < n; i++)
			send_item(CMD_TICK, 16'($urandom));
	endtask

	// Pick a beep period: mostly tiny so the pattern wraps many times,
	// sometimes medium, rarely anything at all (including zero).
	function automatic logic [15:0] pick_period();
		int r;
		r = $urandom_range(0, 9);
		if (r <= 5)
			return 16'($urandom_range(1, 12));
		else if (r <= 7)
			return 16'($urandom_range(13, 200));
		else if (r == 8)
			return 16'($urandom_range(201, 4000));
		else
			return 16'($urandom);
	endfunction

	initial begin
		int pick;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed part: stopped state, failing requests, all phases, extremes
		send_item(CMD_TICK, 16'hFFFF);        // tick while stopped
		send_item(CMD_HALT, 16'h0000);        // halt while stopped
		send_item(CMD_FREQ, 16'h0000);        // zero frequency fails
		send_item(3'd5, 16'hFFFF);            // unknown commands fail
		send_item(3'd6, 16'h5555);
		send_item(3'd7, 16'hAAAA);
		// frequency one: on and off times are zero, each phase lasts one tick,
		// so nine ticks walk all eight phases and wrap
		send_item(CMD_FREQ, 16'd1);
		send_ticks(9);
		send_item(CMD_SETUP, 16'hFFFF);
		send_item(CMD_FREQ, 16'hFFFF);        // largest period
		send_item(CMD_TICK, 16'h0000);
		send_item(CMD_HALT, 16'hFFFF);
		send_item(CMD_TEST, 16'hFFFF);
		send_item(CMD_TICK, 16'h0000);
		send_item(CMD_SETUP, 16'h0000);

		// Random part: mostly pattern runs with short periods
		sent = 0;
		while (sent < ITEM_TARGET) begin
			if (sent >= QUIET_FROM)
				quiet = 1'b1;
			// vary the input gap density, including runs with none
			gap_pct = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(10, 40);
			pick = $urandom_range(0, 99);
			if (pick < 70) begin
				send_item(CMD_FREQ, pick_period());
				send_ticks($urandom_range(5, 150));
			end else if (pick < 78) begin
				send_item(($urandom_range(0, 1) == 0) ? CMD_SETUP : CMD_HALT,
					16'($urandom));
			end else if (pick < 84) begin
				send_item(CMD_TEST, 16'($urandom));
				send_ticks($urandom_range(0, 50));
			end else if (pick < 89) begin
				send_item(CMD_FREQ, 16'h0000);
			end else if (pick < 94) begin
				send_item(3'($urandom_range(5, 7)), 16'($urandom));
			end else begin
				send_ticks($urandom_range(1, 10));
			end
		end
		s_tvalid <= 1'b0;

		// drain outstanding results, then let the pipeline settle
		@(posedge clk);
		while (forecast_depth != 0) @(posedge clk);
		repeat (4) @(posedge clk);

		if (fail_count == 0)
			$display("tb_sounder_beep_pattern_timer_unit OK");
		else
			$display("tb_sounder_beep_pattern_timer_unit NOT OK");
		$finish;
	end

	// Watchdog: end the run when no transfer happens for too long
	initial begin
		int idle_cycles;
		idle_cycles = 0;
		while (idle_cycles < STALL_LIMIT) begin
			@(posedge clk);
			if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
				idle_cycles = 0;
			else
				idle_cycles++;
		end
		$display("tb_sounder_beep_pattern_timer_unit NOT OK");
		$finish;
	end

endmodule
